// ===== sv/profile_affine_gap_align_score_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the profile alignment score block
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PROFILE_AFFINE_GAP_ALIGN_SCORE_DEFINES_SVH
`define PROFILE_AFFINE_GAP_ALIGN_SCORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PAGAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("pagas assertion failed");

// Next-cycle implication, disabled while in reset.
`define PAGAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("pagas assertion failed");

`endif

// ===== sv/pagas_pkg.sv =====
// ----------------------------------------------------------------------------
// pagas_pkg
// Types, constants and saturating arithmetic for the alignment score block.
// ----------------------------------------------------------------------------
package pagas_pkg;

	localparam int CNT_W = 11;
	localparam int SCORE_W = 40;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 24;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [CFG_DW-1:0] pen_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_ROWS     = 3'd0,
		REG_COLS     = 3'd1,
		REG_OPEN     = 3'd2,
		REG_EXTEND   = 3'd3,
		REG_END      = 3'd4,
		REG_FEATURES = 3'd5
	} cfg_reg_t;

	localparam score_t SCORE_MAX = 40'sh7F_FFFF_FFFF;
	localparam score_t SCORE_MIN = 40'sh80_0000_0000;
	localparam score_t NEG_INF   = -40'sd2560000000;

	typedef struct packed {
		score_t v;
		score_t h;
		score_t g;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] prof_val;
		logic signed [31:0] feat_sum;
	} item_t;

	typedef struct packed {
		cnt_t   best_row;
		cnt_t   best_col;
		score_t peak_score;
	} result_t;

	function automatic score_t sat_add(input score_t a, input score_t b);
		logic signed [SCORE_W:0] s;
		s = (SCORE_W+1)'(a) + (SCORE_W+1)'(b);
		if (s[SCORE_W] != s[SCORE_W-1])
			return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
		return s[SCORE_W-1:0];
	endfunction

	function automatic score_t sat_sum3(input score_t a, input logic signed [31:0] b,
			input logic signed [31:0] c);
		logic signed [SCORE_W+1:0] s;
		s = (SCORE_W+2)'(a) + (SCORE_W+2)'(b) + (SCORE_W+2)'(c);
		if (s > (SCORE_W+2)'(SCORE_MAX))
			return SCORE_MAX;
		if (s < (SCORE_W+2)'(SCORE_MIN))
			return SCORE_MIN;
		return s[SCORE_W-1:0];
	endfunction

	function automatic score_t max3(input score_t a, input score_t b, input score_t c);
		score_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// Penalty times a count; the product always fits the score width.
	function automatic score_t end_times(input pen_t ep, input cnt_t k);
		logic signed [CFG_DW+CNT_W:0] p;
		p = ep * $signed({1'b0, k});
		return SCORE_W'(p);
	endfunction

endpackage

// ===== sv/pagas_rowbuf.sv =====
// ----------------------------------------------------------------------------
// pagas_rowbuf
// Previous-row score buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pagas_rowbuf import pagas_pkg::*; #(
	parameter int DEPTH = 1025,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/profile_affine_gap_align_score.sv =====
// ----------------------------------------------------------------------------
// profile_affine_gap_align_score
// Affine-gap profile-to-sequence score fill with best end position report.
// ----------------------------------------------------------------------------
// Items are matrix cells sent in row-major order from (1,1) to
// (profile_rows, sequence_cols); each carries that cell's profile score and
// feature score. The block takes one cell per clock cycle. A cell is read
// from the previous-row buffer on the transfer edge and finished in the
// following cycle, so the single result of a fill goes from stage 1 to the
// output buffer; the next fill may start on the next cycle. Results go to a
// two-entry output buffer, so fills can follow back to back even when every
// fill is a single cell. The only hold-off is on a last cell: it waits while
// both result slots would still be occupied after that edge. Any write to a
// defined register restarts the fill at (1,1); write registers only while
// the block is idle. The row buffer holds no reset state: row 1 takes its
// upper border from logic, and each later row reads what the row above wrote.
// ----------------------------------------------------------------------------
module profile_affine_gap_align_score import pagas_pkg::*; #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result
);

	localparam int AW = $clog2(MAX_COLS + 1);
	localparam cnt_t ROW_LIM = (MAX_ROWS > 2047) ? 11'd2047 : CNT_W'(MAX_ROWS);
	localparam cnt_t COL_LIM = (MAX_COLS > 2047) ? 11'd2047 : CNT_W'(MAX_COLS);

	// configuration registers
	cnt_t rows_q, cols_q;
	pen_t open_q, ext_q, ep_q;
	logic feat_q;

	// fill position of the next cell to transfer
	cnt_t row_q, col_q;

	cnt_t n_eff, m_eff;
	logic restart, accept, first_cell, last_col, last_row, final_cell;

	// stage 1 (cell being finished)
	logic               valid_s1, fwd_s1;
	logic               first_s1, rowone_s1, colone_s1;
	logic               lastcol_s1, lastrow_s1, final_s1;
	cnt_t               row_s1, col_s1;
	logic signed [31:0] ps_s1, fs_s1;
	score_t             epa_s1, epb_s1, epc_s1, epd_s1;
	cell_t              fwd_data_s1;

	cell_t  rd_data, up, diag, left, cell_new;
	cell_t  diag_q, left_q;
	score_t lastcol_score_q, lastrow_score_q;
	cnt_t   lastcol_idx_q, lastrow_idx_q;
	score_t col_base, row_base, col_cand, row_cand;
	score_t col_next, row_next, ep_full, epi, best;
	cnt_t   col_idx_next, row_idx_next, br, bc;
	logic   result_valid_q, skid_valid_q;
	result_t result_q, skid_q, res_new;
	logic   res_push, res_pop;
	logic [1:0] res_level;

	assign restart = cfg_we && (cfg_addr inside {[REG_ROWS:REG_FEATURES]});

	always_comb begin
		n_eff = (rows_q == '0) ? CNT_W'(1) : ((rows_q > ROW_LIM) ? ROW_LIM : rows_q);
		m_eff = (cols_q == '0) ? CNT_W'(1) : ((cols_q > COL_LIM) ? COL_LIM : cols_q);
	end

	assign first_cell = (row_q == CNT_W'(1)) && (col_q == CNT_W'(1));
	assign last_col   = (col_q == m_eff);
	assign last_row   = (row_q == n_eff);
	assign final_cell = last_col && last_row;

	// Result slots in use after this edge, before any last cell taken now.
	assign res_push  = valid_s1 && final_s1;
	assign res_pop   = result_valid_q && result_ready;
	assign res_level = 2'(result_valid_q) + 2'(skid_valid_q) + 2'(res_push) - 2'(res_pop);

	// Hold a last cell while both result slots would still be in use after this edge.
	assign item_ready = !final_cell || (res_level <= 2'd1);
	assign accept = item_valid && item_ready;

	// Configuration writes; any defined index restarts the fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CNT_W'(1);
			cols_q <= CNT_W'(1);
			open_q <= '0;
			ext_q  <= '0;
			ep_q   <= '0;
			feat_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ROWS:     rows_q <= cfg_wdata[CNT_W-1:0];
				REG_COLS:     cols_q <= cfg_wdata[CNT_W-1:0];
				REG_OPEN:     open_q <= cfg_wdata;
				REG_EXTEND:   ext_q  <= cfg_wdata;
				REG_END:      ep_q   <= cfg_wdata;
				REG_FEATURES: feat_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance the fill position on each transfer; wrap after the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= CNT_W'(1);
			col_q <= CNT_W'(1);
		end else if (restart) begin
			row_q <= CNT_W'(1);
			col_q <= CNT_W'(1);
		end else if (accept) begin
			if (final_cell) begin
				row_q <= CNT_W'(1);
				col_q <= CNT_W'(1);
			end else if (last_col) begin
				row_q <= row_q + CNT_W'(1);
				col_q <= CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Capture the cell and its border penalties. On the first cell the epa and
	// epb multipliers produce the end-penalty terms of the scan start.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1   <= first_cell;
			rowone_s1  <= (row_q == CNT_W'(1));
			colone_s1  <= (col_q == CNT_W'(1));
			lastcol_s1 <= last_col && !last_row;
			lastrow_s1 <= last_row && !last_col;
			final_s1   <= final_cell;
			row_s1     <= row_q;
			col_s1     <= col_q;
			ps_s1      <= item.prof_val;
			fs_s1      <= feat_q ? item.feat_sum : '0;
			epa_s1     <= end_times(ep_q, first_cell ? n_eff : col_q);
			epb_s1     <= end_times(ep_q, first_cell ? m_eff : row_q);
			epc_s1     <= end_times(ep_q, n_eff - row_q);
			epd_s1     <= end_times(ep_q, m_eff - col_q);
			// the row above is written back on this same edge when m is 1
			fwd_s1      <= valid_s1 && (col_s1 == col_q);
			fwd_data_s1 <= cell_new;
		end
	end

	pagas_rowbuf #(
		.DEPTH(MAX_COLS + 1),
		.AW   (AW)
	) u_rowbuf (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(AW'(col_s1)),
		.wdata(cell_new),
		.re   (accept),
		.raddr(AW'(col_q)),
		.rdata(rd_data)
	);

	// Cell recurrences. Row 1 sees the top border; column 1 sees the left
	// border for both the diagonal and the left neighbor.
	always_comb begin
		ep_full = SCORE_W'(ep_q);
		epi     = first_s1 ? ep_full : epb_s1;

		if (rowone_s1) begin
			up.v = NEG_INF;
			up.h = NEG_INF;
			up.g = first_s1 ? ep_full : epa_s1;
		end else if (fwd_s1) begin
			up = fwd_data_s1;
		end else begin
			up = rd_data;
		end

		if (colone_s1) begin
			if (rowone_s1) begin
				diag = '0;
			end else begin
				diag.v = NEG_INF;
				diag.h = epi - ep_full;
				diag.g = NEG_INF;
			end
			left.v = NEG_INF;
			left.h = epi;
			left.g = NEG_INF;
		end else begin
			diag = diag_q;
			left = left_q;
		end

		cell_new.v = sat_sum3(max3(diag.v, diag.h, diag.g), ps_s1, fs_s1);
		cell_new.h = max3(sat_add(up.v, SCORE_W'(open_q)), sat_add(up.h, SCORE_W'(ext_q)),
			sat_add(up.g, SCORE_W'(open_q)));
		// horizontal gap pairs the gap terms as the recurrence is written
		cell_new.g = max3(sat_add(left.v, SCORE_W'(open_q)),
			sat_add(left.g, SCORE_W'(ext_q)), sat_add(left.h, SCORE_W'(open_q)));
	end

	// End scans: last column and last row, first strict maximum kept.
	always_comb begin
		col_base = first_s1 ? sat_add(NEG_INF, epa_s1) : lastcol_score_q;
		row_base = first_s1 ? sat_add(NEG_INF, epb_s1) : lastrow_score_q;
		col_idx_next = first_s1 ? '0 : lastcol_idx_q;
		row_idx_next = first_s1 ? '0 : lastrow_idx_q;
		col_cand = sat_add(cell_new.v, epc_s1);
		row_cand = sat_add(cell_new.v, epd_s1);
		col_next = col_base;
		row_next = row_base;
		if (lastcol_s1 && (col_cand > col_base)) begin
			col_next = col_cand;
			col_idx_next = row_s1;
		end
		if (lastrow_s1 && (row_cand > row_base)) begin
			row_next = row_cand;
			row_idx_next = col_s1;
		end

		// corner wins ties
		best = cell_new.v;
		br = row_s1;
		bc = col_s1;
		if (col_next > best) begin
			best = col_next;
			br = col_idx_next;
		end
		if (row_next > best) begin
			best = row_next;
			br = row_s1;
			bc = row_idx_next;
		end
	end

	assign res_new = {br, bc, best};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			diag_q          <= up;
			left_q          <= cell_new;
			lastcol_score_q <= col_next;
			lastrow_score_q <= row_next;
			lastcol_idx_q   <= col_idx_next;
			lastrow_idx_q   <= row_idx_next;
		end
	end

	// Two result slots: the head drives the port and holds until its
	// transfer; the second slot takes a result that lands while the head
	// waits. Refill the head from the second slot, else from the new result.
	always_ff @(posedge clk) begin
		if (!result_valid_q || res_pop) begin
			result_q <= skid_valid_q ? skid_q : res_new;
		end
		if (res_push) begin
			skid_q <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else begin
			result_valid_q <= (res_level != 2'd0);
			skid_valid_q   <= (res_level == 2'd2);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/pagas_chk.sv =====
// ----------------------------------------------------------------------------
// pagas_chk
// Port-level checks for the alignment score block, bound to the top level.
// ----------------------------------------------------------------------------
`include "profile_affine_gap_align_score_defines.svh"

module pagas_chk import pagas_pkg::*; #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	`PAGAS_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`PAGAS_ASSERT_NOW(a_pos_in_range, clk, arst_n, result_valid, (32'(result.best_row) <= MAX_ROWS) && (32'(result.best_col) <= MAX_COLS))
	`PAGAS_ASSERT_NOW(a_pos_not_origin, clk, arst_n, result_valid, (result.best_row != '0) || (result.best_col != '0))
	`PAGAS_ASSERT_NOW(a_ready_when_free, clk, arst_n, item_valid && !result_valid, item_ready)

endmodule

bind profile_affine_gap_align_score pagas_chk #(
	.MAX_ROWS(MAX_ROWS),
	.MAX_COLS(MAX_COLS)
) u_pagas_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
